// ----- design/rc4_pkg.sv -----
// Shared types and constants of the RC4 stream cipher engine.
// Used by rc4_core and rc4_stream_cipher; depends on nothing else.

package rc4_pkg;

	// Operation codes carried in the func field of a request.
	localparam logic [1:0] FUNC_KEY_WRITE = 2'd0;
	localparam logic [1:0] FUNC_SCHEDULE  = 2'd1;
	localparam logic [1:0] FUNC_CRYPT     = 2'd2;

	// Last entry of the 256-byte permutation.
	localparam logic [7:0] BYTE_MAX   = 8'hff;
	localparam int         PERM_DEPTH = 256;

	// Request handed from the top level to the core at acceptance.
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data;
		logic       last;
	} core_req_t;

	// Result presented by the core.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       not_keyed;
	} core_res_t;

	// Core status seen by the top level.
	typedef struct packed {
		logic idle;
		logic keyed;
	} core_stat_t;

endpackage

// ----- design/rc4_key_store.sv -----
// Key byte store: one write port, one read port with registered read data.
// Standalone memory module; depends on nothing else.

module rc4_key_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/rc4_core.sv -----
// RC4 core: permutation memory, index registers and the sequencer for the
// key schedule and the output generator. Depends on rc4_pkg.

module rc4_core #(
	parameter int KEY_AW = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  rc4_pkg::core_req_t    req,
	input  logic [KEY_AW-1:0]     len_last,
	output logic                  key_rd_en,
	output logic [KEY_AW-1:0]     key_rd_addr,
	input  logic [7:0]            key_rd_data,
	output logic                  res_valid,
	output rc4_pkg::core_res_t    res,
	input  logic                  res_ready,
	output rc4_pkg::core_stat_t   stat
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD,
		ST_KS_J,
		ST_KS_WI,
		ST_KS_WJ,
		ST_CR_J,
		ST_CR_WI,
		ST_CR_WJ,
		ST_NK_OUT
	} state_t;

	state_t state_q;
	logic [7:0]        i_q;
	logic [7:0]        j_q;
	logic [KEY_AW-1:0] pos_q;
	logic              keyed_q;
	logic [7:0]        si_q;
	logic [7:0]        sj_q;
	logic [7:0]        data_q;
	logic              last_q;

	// Permutation memory and its port signals.
	logic [7:0] perm_mem [rc4_pkg::PERM_DEPTH];
	logic [7:0] rdata_q;
	logic       mem_re;
	logic [7:0] mem_raddr;
	logic       mem_we;
	logic [7:0] mem_waddr;
	logic [7:0] mem_wdata;

	logic [7:0] ks_j_next;
	logic [7:0] cr_j_next;
	logic [7:0] ks_addr;
	logic [7:0] ks_byte;

	// Index arithmetic of the schedule and generator steps.
	assign ks_j_next = j_q + rdata_q + key_rd_data;
	assign cr_j_next = j_q + rdata_q;
	assign ks_addr   = si_q + sj_q;

	// The keystream read overlaps the write of S[i] and misses the write of
	// S[j]; patch the value read with the two swapped bytes.
	always_comb begin
		priority if (ks_addr == j_q) begin
			ks_byte = si_q;
		end else if (ks_addr == i_q) begin
			ks_byte = sj_q;
		end else begin
			ks_byte = rdata_q;
		end
	end

	// Memory port control.
	always_comb begin
		mem_re      = 1'b0;
		mem_raddr   = i_q;
		mem_we      = 1'b0;
		mem_waddr   = i_q;
		mem_wdata   = rdata_q;
		key_rd_en   = 1'b0;
		key_rd_addr = pos_q;
		unique case (state_q)
			ST_IDLE: begin
				mem_re    = start && (req.func == rc4_pkg::FUNC_CRYPT) && keyed_q;
				mem_raddr = i_q + 8'd1;
			end
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = i_q;
			end
			ST_KS_RD: begin
				mem_re    = 1'b1;
				key_rd_en = 1'b1;
			end
			ST_KS_J: begin
				mem_re    = 1'b1;
				mem_raddr = ks_j_next;
			end
			ST_KS_WI: begin
				mem_we = 1'b1;
			end
			ST_KS_WJ: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = si_q;
			end
			ST_CR_J: begin
				mem_re    = 1'b1;
				mem_raddr = cr_j_next;
			end
			ST_CR_WI: begin
				mem_we    = 1'b1;
				mem_re    = 1'b1;
				mem_raddr = si_q + rdata_q;
			end
			ST_CR_WJ: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = si_q;
			end
			ST_NK_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Permutation memory: read data registered, held between reads.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			perm_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= perm_mem[mem_raddr];
		end
	end

	// Result presented to the output register.
	always_comb begin
		res_valid     = (state_q == ST_CR_WJ) || (state_q == ST_NK_OUT);
		res.last      = last_q;
		res.not_keyed = (state_q == ST_NK_OUT);
		res.data      = (state_q == ST_NK_OUT) ? data_q : (data_q ^ ks_byte);
	end

	assign stat.idle  = (state_q == ST_IDLE);
	assign stat.keyed = keyed_q;

	// Sequencer and index registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			pos_q   <= '0;
			keyed_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					data_q <= req.data;
					last_q <= req.last;
					if (start) begin
						priority if (req.func == rc4_pkg::FUNC_SCHEDULE) begin
							i_q     <= '0;
							j_q     <= '0;
							pos_q   <= '0;
							state_q <= ST_INIT;
						end else if (req.func == rc4_pkg::FUNC_CRYPT && keyed_q) begin
							i_q     <= i_q + 8'd1;
							state_q <= ST_CR_J;
						end else if (req.func == rc4_pkg::FUNC_CRYPT) begin
							state_q <= ST_NK_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				// Identity fill, one entry a cycle; i wraps back to zero.
				ST_INIT: begin
					i_q <= i_q + 8'd1;
					if (i_q == rc4_pkg::BYTE_MAX) begin
						state_q <= ST_KS_RD;
					end
				end
				ST_KS_RD: begin
					state_q <= ST_KS_J;
				end
				ST_KS_J: begin
					si_q    <= rdata_q;
					j_q     <= ks_j_next;
					state_q <= ST_KS_WI;
				end
				ST_KS_WI: begin
					state_q <= ST_KS_WJ;
				end
				// Close one swap step; the key position wraps at the key length.
				ST_KS_WJ: begin
					i_q   <= i_q + 8'd1;
					pos_q <= (pos_q == len_last) ? '0 : pos_q + 1'b1;
					if (i_q == rc4_pkg::BYTE_MAX) begin
						j_q     <= '0;
						keyed_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_KS_RD;
					end
				end
				ST_CR_J: begin
					si_q    <= rdata_q;
					j_q     <= cr_j_next;
					state_q <= ST_CR_WI;
				end
				ST_CR_WI: begin
					sj_q    <= rdata_q;
					state_q <= ST_CR_WJ;
				end
				// Hold the result (rewriting S[j] is harmless) until it is taken.
				ST_CR_WJ: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_NK_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/rc4_stream_cipher.sv -----
// RC4 engine top level: request handshake, key length register, output register.
// Depends on rc4_pkg, rc4_key_store and rc4_core.

// A request carries func: a key write stores key_byte at key_index (indexes at
// or beyond KEY_DEPTH are dropped), a schedule runs the RC4 key schedule over
// the first key_length key bytes, and a crypt returns data_in XOR the next
// keystream byte together with last_out. Before any schedule a crypt returns
// data_in unchanged with not_keyed set. A keyed crypt reads S[i], reads S[j],
// and then makes the two write-backs, the first together with the keystream
// read, one after another: the permutation memory has one write port and
// registered read data. A schedule accepts the request, fills the identity,
// and then runs 256 swap steps on the same memory port. Input requests are
// taken whenever the core is idle, even while a result waits in the output
// register. key_length is written on cfg_wr_en; 0 acts as 1 and values above
// KEY_DEPTH act as KEY_DEPTH. Key bytes up to key_length must be written
// before a schedule.

module rc4_stream_cipher #(
	parameter int KEY_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [5:0] key_index,
	input  logic [7:0] key_byte,
	input  logic [7:0] data_in,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_out,
	output logic       last_out,
	output logic       not_keyed,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data
);

	localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

	logic [6:0]          key_length_q;
	logic [8:0]          len_wide;
	logic [KEY_AW-1:0]   len_last;
	logic [8:0]          key_index_wide;
	logic                in_accept;
	logic                key_wr_en;
	logic                key_rd_en;
	logic [KEY_AW-1:0]   key_rd_addr;
	logic [7:0]          key_rd_data;
	rc4_pkg::core_req_t  core_req;
	rc4_pkg::core_res_t  core_res;
	rc4_pkg::core_stat_t core_stat;
	logic                res_valid;
	logic                res_ready;
	logic                out_valid_q;
	logic [7:0]          data_out_q;
	logic                last_out_q;
	logic                not_keyed_q;

	// Key length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= 7'd16;
		end else if (cfg_wr_en) begin
			key_length_q <= cfg_wr_data;
		end
	end

	// Last key position used by the schedule, after saturation.
	assign len_wide = {2'b00, key_length_q};
	always_comb begin
		priority if (len_wide == 9'd0) begin
			len_last = '0;
		end else if (len_wide > 9'(KEY_DEPTH)) begin
			len_last = KEY_AW'(KEY_DEPTH - 1);
		end else begin
			len_last = KEY_AW'(len_wide - 9'd1);
		end
	end

	// Request acceptance and key write decode.
	assign in_stall       = !core_stat.idle;
	assign in_accept      = in_valid && !in_stall;
	assign key_index_wide = {3'b000, key_index};
	assign key_wr_en      = in_accept && (func == rc4_pkg::FUNC_KEY_WRITE)
		&& (key_index_wide < 9'(KEY_DEPTH));

	assign core_req.func = func;
	assign core_req.data = data_in;
	assign core_req.last = last_byte;

	rc4_key_store #(
		.DEPTH (KEY_DEPTH),
		.AW    (KEY_AW)
	) u_key_store (
		.clk     (clk),
		.wr_en   (key_wr_en),
		.wr_addr (KEY_AW'(key_index_wide)),
		.wr_data (key_byte),
		.rd_en   (key_rd_en),
		.rd_addr (key_rd_addr),
		.rd_data (key_rd_data)
	);

	rc4_core #(
		.KEY_AW (KEY_AW)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_accept),
		.req         (core_req),
		.len_last    (len_last),
		.key_rd_en   (key_rd_en),
		.key_rd_addr (key_rd_addr),
		.key_rd_data (key_rd_data),
		.res_valid   (res_valid),
		.res         (core_res),
		.res_ready   (res_ready),
		.stat        (core_stat)
	);

	// Output register: loads when empty or when its result leaves this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			data_out_q  <= core_res.data;
			last_out_q  <= core_res.last;
			not_keyed_q <= core_res.not_keyed;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign last_out  = last_out_q;
	assign not_keyed = not_keyed_q;

	// Once keyed, the engine stays keyed.
	assert property (@(posedge clk) disable iff (!arst_n)
		core_stat.keyed |=> core_stat.keyed)
		else $error("keyed state was lost");

	// The core never offers a result while idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !core_stat.idle)
		else $error("result offered by an idle core");

	// An accepted schedule request keeps the core busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && func == rc4_pkg::FUNC_SCHEDULE) |=> !core_stat.idle)
		else $error("schedule request did not start the core");

endmodule
